/* hw/rtl/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher block.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package rc4_pkg;

    // Byte and table geometry
    localparam int BYTE_W      = 8;
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_MAX_LEN = 16;
    localparam int KPOS_W      = $clog2(KEY_MAX_LEN);
    localparam int KLEN_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LOW    = 2'd0,
        CFG_KEY_HIGH   = 2'd1,
        CFG_KEY_LENGTH = 2'd2
    } cfg_index_t;

    // Sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE   = 11'b000_0000_0001,
        ST_KS_RDN = 11'b000_0000_0010,
        ST_KS_RDJ = 11'b000_0000_0100,
        ST_KS_WRN = 11'b000_0000_1000,
        ST_KS_WRJ = 11'b000_0001_0000,
        ST_PR_RDI = 11'b000_0010_0000,
        ST_PR_RDJ = 11'b000_0100_0000,
        ST_PR_WRI = 11'b000_1000_0000,
        ST_PR_WRJ = 11'b001_0000_0000,
        ST_PR_RDT = 11'b010_0000_0000,
        ST_PR_OUT = 11'b100_0000_0000
    } state_t;

endpackage

/* hw/rtl/rc4_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; instantiated by the top level for the permutation table.
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on we, read otherwise; read data holds while idle
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/rc4_stream_cipher_top.sv */
// RC4 stream cipher top level: config registers, sequencer, shared adder.
// Depends on rc4_pkg and rc4_ram.
`timescale 1ns / 1ps

// Usage
//   s_* channel: one word per data byte. s_tdata carries the byte, s_tuser
//   marks the first byte of a new message; such a word first runs the key
//   schedule (identity table, indices cleared) over the current key.
//   m_* channel: one word per input word, the byte XORed with the keystream.
//   cfg_* channel: register writes (index 0 key_low, 1 key_high,
//   2 key_length); always ready, write only while no word is in flight.
// Sequencing
//   A data byte runs through PR_RDI, PR_RDJ, PR_WRI, PR_WRJ, PR_RDT and
//   PR_OUT before the next word is accepted; m_tvalid rises once PR_OUT
//   loads the output register. A word with s_tuser set first runs the
//   key schedule: 256 steps of KS_RDN, KS_RDJ, KS_WRN and KS_WRJ. Every
//   access takes the single RAM port in turn; the 8-bit adder is shared.
// Reset
//   aresetn (synchronous, low) restores the key registers, clears both
//   indices and marks the whole table as identity at once; no fill pass.
// Stall
//   A finished word sits in the output register; the next word is accepted
//   meanwhile, and its result waits until the previous one is taken.
module rc4_stream_cipher_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input byte stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [0:0]                       s_tuser,   // [0] new_message
    // output byte stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int BW = rc4_pkg::BYTE_W;
    localparam int AW = $clog2(rc4_pkg::TABLE_DEPTH);

    rc4_pkg::state_t state_reg, state_next;

    logic [rc4_pkg::CFG_DATA_W-1:0] key_low_reg, key_high_reg;
    logic [rc4_pkg::KLEN_W-1:0]     key_len_reg;

    logic [AW-1:0]                  n_reg, n_next;
    logic [rc4_pkg::KPOS_W-1:0]     kpos_reg, kpos_next;
    logic [AW-1:0]                  idx_i_reg, idx_i_next;
    logic [AW-1:0]                  idx_j_reg, idx_j_next;
    logic [BW-1:0]                  si_reg, si_next;
    logic [BW-1:0]                  sj_reg, sj_next;
    logic [BW-1:0]                  data_reg, data_next;
    logic [BW-1:0]                  out_reg, out_next;
    logic                           m_valid_reg, m_valid_next;
    logic [rc4_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [AW-1:0]                  rd_addr_reg, rd_addr_next;

    logic                           ram_en, ram_we;
    logic [AW-1:0]                  ram_addr;
    logic [BW-1:0]                  ram_wdata, ram_rdata;
    logic [BW-1:0]                  rd_fix;

    logic [BW-1:0]                  add_a, add_b, add_c, add_sum;
    logic [2*rc4_pkg::CFG_DATA_W-1:0] key_all;
    logic [BW-1:0]                  key_byte;
    logic [rc4_pkg::KLEN_W-1:0]     len_used;
    logic [rc4_pkg::KLEN_W-1:0]     kpos_inc;
    logic                           in_fire;
    logic                           out_free;

    rc4_ram #(
        .WIDTH(BW),
        .DEPTH(rc4_pkg::TABLE_DEPTH)
    ) u_perm (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    // Handshakes
    assign s_tready  = (state_reg == rc4_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = out_reg;
    assign out_free  = !m_valid_reg || m_tready;

    // Entries never written since the last clear read as their own index
    assign rd_fix = valid_reg[rd_addr_reg] ? ram_rdata : rd_addr_reg;

    // Key byte at the current schedule position, clamped key length
    assign key_all  = {key_high_reg, key_low_reg};
    assign key_byte = key_all[{kpos_reg, 3'b000} +: BW];
    always_comb begin
        if (key_len_reg == '0) begin
            len_used = rc4_pkg::KLEN_W'(1);
        end else if (key_len_reg > rc4_pkg::KLEN_W'(rc4_pkg::KEY_MAX_LEN)) begin
            len_used = rc4_pkg::KLEN_W'(rc4_pkg::KEY_MAX_LEN);
        end else begin
            len_used = key_len_reg;
        end
    end
    assign kpos_inc = {1'b0, kpos_reg} + rc4_pkg::KLEN_W'(1);

    // Shared adder: operands chosen by state
    always_comb begin
        add_a = idx_j_reg;
        add_b = rd_fix;
        add_c = '0;
        unique case (state_reg)
            rc4_pkg::ST_KS_RDJ: add_c = key_byte;
            rc4_pkg::ST_PR_RDT: begin
                add_a = si_reg;
                add_b = sj_reg;
            end
            default: ;
        endcase
    end
    assign add_sum = add_a + add_b + add_c;

    // Sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        kpos_next    = kpos_reg;
        idx_i_next   = idx_i_reg;
        idx_j_next   = idx_j_reg;
        si_next      = si_reg;
        sj_next      = sj_reg;
        data_next    = data_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_tready;
        valid_next   = valid_reg;
        rd_addr_next = rd_addr_reg;
        ram_en       = 1'b0;
        ram_we       = 1'b0;
        ram_addr     = n_reg;
        ram_wdata    = rd_fix;

        unique case (state_reg)
            rc4_pkg::ST_IDLE: begin
                if (in_fire) begin
                    data_next = s_tdata;
                    if (s_tuser[0]) begin
                        valid_next = '0;
                        n_next     = '0;
                        kpos_next  = '0;
                        idx_j_next = '0;
                        state_next = rc4_pkg::ST_KS_RDN;
                    end else begin
                        state_next = rc4_pkg::ST_PR_RDI;
                    end
                end
            end
            // Key schedule: read s[n]
            rc4_pkg::ST_KS_RDN: begin
                ram_en       = 1'b1;
                ram_addr     = n_reg;
                rd_addr_next = n_reg;
                state_next   = rc4_pkg::ST_KS_RDJ;
            end
            // Advance j by s[n] and the key byte, read s[j]
            rc4_pkg::ST_KS_RDJ: begin
                si_next      = rd_fix;
                idx_j_next   = add_sum;
                ram_en       = 1'b1;
                ram_addr     = add_sum;
                rd_addr_next = add_sum;
                state_next   = rc4_pkg::ST_KS_WRN;
            end
            // Write s[n] = old s[j]
            rc4_pkg::ST_KS_WRN: begin
                ram_en            = 1'b1;
                ram_we            = 1'b1;
                ram_addr          = n_reg;
                ram_wdata         = rd_fix;
                valid_next[n_reg] = 1'b1;
                state_next        = rc4_pkg::ST_KS_WRJ;
            end
            // Write s[j] = old s[n], step position
            rc4_pkg::ST_KS_WRJ: begin
                ram_en                = 1'b1;
                ram_we                = 1'b1;
                ram_addr              = idx_j_reg;
                ram_wdata             = si_reg;
                valid_next[idx_j_reg] = 1'b1;
                n_next                = n_reg + AW'(1);
                kpos_next = (kpos_inc >= len_used) ? '0 : kpos_inc[rc4_pkg::KPOS_W-1:0];
                if (n_reg == AW'(rc4_pkg::TABLE_DEPTH - 1)) begin
                    idx_i_next = '0;
                    idx_j_next = '0;
                    state_next = rc4_pkg::ST_PR_RDI;
                end else begin
                    state_next = rc4_pkg::ST_KS_RDN;
                end
            end
            // Keystream: advance i, read s[i]
            rc4_pkg::ST_PR_RDI: begin
                idx_i_next   = idx_i_reg + AW'(1);
                ram_en       = 1'b1;
                ram_addr     = idx_i_reg + AW'(1);
                rd_addr_next = idx_i_reg + AW'(1);
                state_next   = rc4_pkg::ST_PR_RDJ;
            end
            // Advance j by s[i], read s[j]
            rc4_pkg::ST_PR_RDJ: begin
                si_next      = rd_fix;
                idx_j_next   = add_sum;
                ram_en       = 1'b1;
                ram_addr     = add_sum;
                rd_addr_next = add_sum;
                state_next   = rc4_pkg::ST_PR_WRI;
            end
            // Write s[i] = old s[j]
            rc4_pkg::ST_PR_WRI: begin
                sj_next               = rd_fix;
                ram_en                = 1'b1;
                ram_we                = 1'b1;
                ram_addr              = idx_i_reg;
                ram_wdata             = rd_fix;
                valid_next[idx_i_reg] = 1'b1;
                state_next            = rc4_pkg::ST_PR_WRJ;
            end
            // Write s[j] = old s[i]
            rc4_pkg::ST_PR_WRJ: begin
                ram_en                = 1'b1;
                ram_we                = 1'b1;
                ram_addr              = idx_j_reg;
                ram_wdata             = si_reg;
                valid_next[idx_j_reg] = 1'b1;
                state_next            = rc4_pkg::ST_PR_RDT;
            end
            // Read s[s[i] + s[j]]
            rc4_pkg::ST_PR_RDT: begin
                ram_en       = 1'b1;
                ram_addr     = add_sum;
                rd_addr_next = add_sum;
                state_next   = rc4_pkg::ST_PR_OUT;
            end
            // Hold until the output register is free, then load the word
            rc4_pkg::ST_PR_OUT: begin
                if (out_free) begin
                    out_next     = data_reg ^ rd_fix;
                    m_valid_next = 1'b1;
                    state_next   = rc4_pkg::ST_IDLE;
                end
            end
            default: state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rc4_pkg::ST_IDLE;
            idx_i_reg    <= '0;
            idx_j_reg    <= '0;
            m_valid_reg  <= 1'b0;
            valid_reg    <= '0;
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= rc4_pkg::KLEN_W'(rc4_pkg::KEY_MAX_LEN);
        end else begin
            state_reg   <= state_next;
            idx_i_reg   <= idx_i_next;
            idx_j_reg   <= idx_j_next;
            m_valid_reg <= m_valid_next;
            valid_reg   <= valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    rc4_pkg::CFG_KEY_LOW:    key_low_reg  <= cfg_data;
                    rc4_pkg::CFG_KEY_HIGH:   key_high_reg <= cfg_data;
                    rc4_pkg::CFG_KEY_LENGTH: key_len_reg  <= cfg_data[rc4_pkg::KLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        kpos_reg    <= kpos_next;
        si_reg      <= si_next;
        sj_reg      <= sj_next;
        data_reg    <= data_next;
        out_reg     <= out_next;
        rd_addr_reg <= rd_addr_next;
    end

endmodule
